/* rtl/fnas_pkg.sv */
// ----------------------------------------------------------------------------
// fnas_pkg
// shared constants and types for the four-neighbor average stencil unit
// ----------------------------------------------------------------------------
package fnas_pkg;

    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int ROW_W       = 16;
    localparam int GRID_COLS_W = 11;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [ROW_W-1:0]       ROWS_RESET = 16'd102;
    localparam logic [GRID_COLS_W-1:0] COLS_RESET = 11'd102;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } cfg_reg_t;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_LVL_W = 2;

endpackage

/* rtl/fnas_line_store.sv */
// ----------------------------------------------------------------------------
// fnas_line_store
// two-row line store: each entry holds {row r-2, row r-1} of one column,
// one write port and two registered read ports
// ----------------------------------------------------------------------------
module fnas_line_store #(
    parameter int DEPTH  = fnas_pkg::DEF_MAX_COLS,
    parameter int WIDTH  = 2 * fnas_pkg::DEF_DATA_WIDTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

/* rtl/fnas_out_fifo.sv */
// ----------------------------------------------------------------------------
// fnas_out_fifo
// three-entry result queue between the compute stage and the output channel
// ----------------------------------------------------------------------------
module fnas_out_fifo #(
    parameter int DATA_WIDTH = fnas_pkg::DEF_DATA_WIDTH,
    parameter int COL_W      = $clog2(fnas_pkg::DEF_MAX_COLS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [DATA_WIDTH-1:0]            push_average,
    input  logic [fnas_pkg::ROW_W-1:0]       push_row,
    input  logic [COL_W-1:0]                 push_col,
    input  logic                             push_done,
    output logic [fnas_pkg::FIFO_LVL_W-1:0]  level,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [DATA_WIDTH-1:0]            average,
    output logic [fnas_pkg::ROW_W-1:0]       cell_row,
    output logic [COL_W-1:0]                 cell_col,
    output logic                             frame_done
);

    import fnas_pkg::*;

    localparam int ENTRY_W = DATA_WIDTH + ROW_W + COL_W + 1;

    logic [ENTRY_W-1:0]    entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] head_reg, head_next;
    logic [FIFO_PTR_W-1:0] tail_reg, tail_next;
    logic [FIFO_LVL_W-1:0] level_reg, level_next;
    logic                  pop;
    logic [ENTRY_W-1:0]    head_entry;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        ptr_inc = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_valid  = (level_reg != '0);
    assign pop        = out_valid && out_ready;
    assign level      = level_reg;
    assign head_entry = entry_reg[head_reg];

    assign average    = head_entry[ENTRY_W-1 -: DATA_WIDTH];
    assign cell_row   = head_entry[COL_W+1 +: ROW_W];
    assign cell_col   = head_entry[1 +: COL_W];
    assign frame_done = head_entry[0];

    always_comb
    begin
        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        tail_next  = push ? ptr_inc(tail_reg) : tail_reg;
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= {push_average, push_row, push_col, push_done};
        end
    end

endmodule

/* rtl/four_neighbor_average_stencil_unit.sv */
// ----------------------------------------------------------------------------
// four_neighbor_average_stencil_unit
// four-point jacobi stencil over a raster-order grid stream
//
// samples enter on in_valid/in_ready in raster order, one per clock at full
// rate. each interior cell (r, c) gives one result, (up+down+left+right)/4
// truncated toward zero, tagged with cell_row/cell_col, on out_valid/out_ready
// when the sample directly below it is taken; frame_done flags the last
// interior cell of the frame. boundary cells give no result.
// grid_rows (index 0) and grid_cols (index 1) are written through cfg_write; the user must
// write them only while the unit is idle, which the unit itself does not enforce; they act on the next sample.
// a result passes the compute stage, where the line store is read, and then
// the result queue before it can transfer.
// throughput: one sample per cycle, set by the two read ports and one write
// port of the line store, with the pending write forwarded to the reads.
// the three-entry result queue keeps the input open while results wait;
// when the receiver stalls it fills and in_ready drops until it drains.
// reset clears the position counters and the queue and loads 102 x 102;
// line store contents are undefined until the first frame has passed.
// ----------------------------------------------------------------------------
module four_neighbor_average_stencil_unit #(
    parameter int MAX_COLS   = fnas_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = fnas_pkg::DEF_DATA_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [fnas_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fnas_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [DATA_WIDTH-1:0]       sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [DATA_WIDTH-1:0]       average,
    output logic [fnas_pkg::ROW_W-1:0]         cell_row,
    output logic [$clog2(MAX_COLS)-1:0]        cell_col,
    output logic                               frame_done
);

    import fnas_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int EW    = CW + 1;
    localparam int CMPW  = (EW > GRID_COLS_W) ? EW : GRID_COLS_W;
    localparam int RW1   = ROW_W + 1;
    localparam int SUM_W = DATA_WIDTH + 2;

    // configuration
    logic [ROW_W-1:0]       grid_rows_reg;
    logic [GRID_COLS_W-1:0] grid_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= ROWS_RESET;
            grid_cols_reg <= COLS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data[ROW_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= cfg_data[GRID_COLS_W-1:0];
            endcase
        end
    end

    logic [CMPW-1:0]  cols_clip;
    logic [CMPW-1:0]  eff_cols;
    logic [ROW_W-1:0] eff_rows;
    logic [RW1-1:0]   rows_x;

    always_comb
    begin
        cols_clip = (CMPW'(grid_cols_reg) > CMPW'(MAX_COLS)) ? CMPW'(MAX_COLS)
                                                             : CMPW'(grid_cols_reg);
        eff_cols  = (cols_clip == '0) ? CMPW'(1) : cols_clip;
        eff_rows  = (grid_rows_reg == '0) ? ROW_W'(1) : grid_rows_reg;
        rows_x    = RW1'(eff_rows);
    end

    // position counters and issue stage
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [CW-1:0]    col_count_reg, col_count_next;
    logic             accept;
    logic             restart;
    logic [ROW_W-1:0] r;
    logic [CW-1:0]    c;
    logic [CMPW-1:0]  c_x;
    logic [CMPW-1:0]  c_inc;
    logic [CMPW-1:0]  c_add2;
    logic [RW1-1:0]   r_inc;
    logic             produce;
    logic             last_cell;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        restart   = (row_count_reg >= eff_rows) || (CMPW'(col_count_reg) >= eff_cols);
        r         = restart ? '0 : row_count_reg;
        c         = restart ? '0 : col_count_reg;
        c_x       = CMPW'(c);
        c_inc     = c_x + CMPW'(1);
        c_add2    = c_x + CMPW'(2);
        r_inc     = RW1'(r) + RW1'(1);
        produce   = (r >= ROW_W'(2)) && (r_inc <= rows_x) && (c != '0) && (c_add2 <= eff_cols);
        last_cell = (r_inc == rows_x) && (c_add2 == eff_cols);

        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (accept)
        begin
            if (c_inc >= eff_cols)
            begin
                col_count_next = '0;
                row_count_next = (r_inc >= rows_x) ? '0 : r_inc[ROW_W-1:0];
            end
            else
            begin
                col_count_next = c_inc[CW-1:0];
                row_count_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // compute stage
    logic                        s1_valid_reg;
    logic signed [DATA_WIDTH-1:0] s1_sample_reg;
    logic [ROW_W-1:0]            s1_row_reg;
    logic [CW-1:0]               s1_col_reg;
    logic                        s1_produce_reg;
    logic                        s1_done_reg;
    logic                        fwd_a_reg;
    logic                        fwd_b_reg;
    logic [2*DATA_WIDTH-1:0]     fwd_data_reg;
    logic [DATA_WIDTH-1:0]       left_reg;

    logic [2*DATA_WIDTH-1:0]     rd_data_a;
    logic [2*DATA_WIDTH-1:0]     rd_data_b;
    logic [2*DATA_WIDTH-1:0]     entry_a;
    logic [2*DATA_WIDTH-1:0]     entry_b;
    logic [DATA_WIDTH-1:0]       up;
    logic [DATA_WIDTH-1:0]       centre;
    logic [DATA_WIDTH-1:0]       right;
    logic [2*DATA_WIDTH-1:0]     wr_data;
    logic signed [SUM_W-1:0]     sum;
    logic signed [SUM_W-1:0]     sum_adj;
    logic [DATA_WIDTH-1:0]       avg;
    logic                        push;

    function automatic logic signed [SUM_W-1:0] sx(input logic [DATA_WIDTH-1:0] v);
        sx = {{2{v[DATA_WIDTH-1]}}, v};
    endfunction

    fnas_line_store #(
        .DEPTH  (MAX_COLS),
        .WIDTH  (2 * DATA_WIDTH),
        .ADDR_W (CW)
    ) u_line_store (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr_a (c),
        .rd_addr_b (c_inc[CW-1:0]),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (s1_valid_reg),
        .wr_addr   (s1_col_reg),
        .wr_data   (wr_data)
    );

    always_comb
    begin
        entry_a = fwd_a_reg ? fwd_data_reg : rd_data_a;
        entry_b = fwd_b_reg ? fwd_data_reg : rd_data_b;
        up      = entry_a[2*DATA_WIDTH-1:DATA_WIDTH];
        centre  = entry_a[DATA_WIDTH-1:0];
        right   = entry_b[DATA_WIDTH-1:0];
        // entry c shifts down one row: old middle becomes above
        wr_data = {centre, s1_sample_reg};
        sum     = sx(up) + sx(s1_sample_reg) + sx(left_reg) + sx(right);
        // bias negative sums so the shift truncates toward zero
        sum_adj = sum + (sum[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
        avg     = sum_adj[SUM_W-1:2];
        push    = s1_valid_reg && s1_produce_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            left_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                left_reg <= centre;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg  <= sample;
            s1_row_reg     <= r - ROW_W'(1);
            s1_col_reg     <= c;
            s1_produce_reg <= produce;
            s1_done_reg    <= last_cell;
            // the write in flight is not yet in the store for these reads
            fwd_a_reg      <= s1_valid_reg && (s1_col_reg == c);
            fwd_b_reg      <= s1_valid_reg && (s1_col_reg == c_inc[CW-1:0]);
            fwd_data_reg   <= wr_data;
        end
    end

    // result queue
    logic [FIFO_LVL_W-1:0] fifo_level;

    fnas_out_fifo #(
        .DATA_WIDTH (DATA_WIDTH),
        .COL_W      (CW)
    ) u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_average (avg),
        .push_row     (s1_row_reg),
        .push_col     (s1_col_reg),
        .push_done    (s1_done_reg),
        .level        (fifo_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .average      (average),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .frame_done   (frame_done)
    );

    // room for the item in the compute stage plus the new one
    assign in_ready = ((FIFO_LVL_W + 1)'(fifo_level) + (FIFO_LVL_W + 1)'(s1_valid_reg))
                      < (FIFO_LVL_W + 1)'(FIFO_DEPTH);

`ifndef ASSERT_OFF
    a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_level != FIFO_LVL_W'(FIFO_DEPTH)) || (out_valid && out_ready))
        else $error("result queue overflow");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cell_row != '0) && (cell_col != '0))
        else $error("result on a boundary cell");

    a_frame_done_col: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (CMPW'(cell_col) + CMPW'(2) == eff_cols))
        else $error("frame_done away from the last interior column");

    a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (fwd_a_reg || fwd_b_reg)) |-> $past(s1_valid_reg))
        else $error("forward without a pending write");
`endif

endmodule

/* tb/sv/four_neighbor_average_stencil_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_neighbor_average_stencil_checker
// result predictor and scoreboard for the four-neighbor average stencil unit
//
// watches the size register writes and both streaming channels. every sample
// transfer advances its own copy of the raster position, line stores and
// window, and queues the average expected for the interior cell above it.
// every result transfer is compared field by field with the oldest queued
// average. the failure count, the number of averages still owed and the
// number checked go back to the testbench top.
// ----------------------------------------------------------------------------
module four_neighbor_average_stencil_checker (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_write,
    input  logic [fnas_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [fnas_pkg::CFG_DATA_W-1:0]             cfg_data,
    input  logic                                        in_valid,
    input  logic                                        in_ready,
    input  logic signed [fnas_pkg::DEF_DATA_WIDTH-1:0]  sample,
    input  logic                                        out_valid,
    input  logic                                        out_ready,
    input  logic signed [fnas_pkg::DEF_DATA_WIDTH-1:0]  average,
    input  logic [fnas_pkg::ROW_W-1:0]                  cell_row,
    input  logic [$clog2(fnas_pkg::DEF_MAX_COLS)-1:0]   cell_col,
    input  logic                                        frame_done,
    output int                                          error_count,
    output int                                          pending,
    output int                                          checked_count
);
    import fnas_pkg::*;

    localparam int DW         = DEF_DATA_WIDTH;
    localparam int MAXC       = DEF_MAX_COLS;
    localparam int COL_W      = $clog2(MAXC);
    localparam int REPORT_CAP = 40;

    typedef struct {
        logic signed [DW-1:0] avg;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic                 done;
    } cell_average_t;

    cell_average_t          expected_averages[$];
    logic signed [DW-1:0]   up_row_store [MAXC];
    logic signed [DW-1:0]   mid_row_store [MAXC];
    logic signed [DW-1:0]   win_left;
    logic signed [DW-1:0]   win_center;
    logic signed [DW-1:0]   win_right;
    logic [ROW_W-1:0]       rows_setting;
    logic [GRID_COLS_W-1:0] cols_setting;
    int unsigned            row_pos;
    int unsigned            col_pos;

    task automatic report_field(input string field, input longint want, input longint got);
        if (error_count < REPORT_CAP)
            $display("%0t mismatch in %s: expected %0d, actual %0d", $time, field, want, got);
        error_count++;
    endtask

    task automatic check_result();
        cell_average_t want;
        if (expected_averages.size() == 0)
        begin
            if (error_count < REPORT_CAP)
                $display("%0t unexpected transfer: expected none, actual average %0d at (%0d, %0d)",
                         $time, average, cell_row, cell_col);
            error_count++;
        end
        else
        begin
            want = expected_averages.pop_front();
            checked_count++;
            if (average !== want.avg)
                report_field("average", want.avg, average);
            if (cell_row !== want.row)
                report_field("cell_row", want.row, cell_row);
            if (cell_col !== want.col)
                report_field("cell_col", want.col, cell_col);
            if (frame_done !== want.done)
                report_field("frame_done", want.done, frame_done);
        end
    endtask

    task automatic predict_cell_average(input logic signed [DW-1:0] s);
        int unsigned   rows_eff;
        int unsigned   cols_eff;
        int unsigned   r;
        int unsigned   c;
        longint        sum;
        cell_average_t res;
        rows_eff = (rows_setting == 0) ? 1 : rows_setting;
        cols_eff = (cols_setting > MAXC) ? MAXC : cols_setting;
        if (cols_eff == 0)
            cols_eff = 1;
        // sizes shrunk under the current position restart the frame
        if (row_pos >= rows_eff || col_pos >= cols_eff)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        win_left   = win_center;
        win_center = mid_row_store[c];
        win_right  = (c + 1 < cols_eff) ? mid_row_store[c + 1] : '0;
        if (r >= 2 && r + 1 <= rows_eff && c >= 1 && c + 2 <= cols_eff)
        begin
            sum = longint'(up_row_store[c]) + longint'(s) + longint'(win_left)
                + longint'(win_right);
            res.avg  = DW'(sum / 4);
            res.row  = ROW_W'(r - 1);
            res.col  = COL_W'(c);
            res.done = (r + 1 == rows_eff && c + 2 == cols_eff);
            expected_averages = {expected_averages, res};
        end
        up_row_store[c]  = win_center;
        mid_row_store[c] = s;
        if (c + 1 >= cols_eff)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= rows_eff) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_averages.delete();
            for (int i = 0; i < MAXC; i++)
            begin
                up_row_store[i]  = '0;
                mid_row_store[i] = '0;
            end
            win_left      = '0;
            win_center    = '0;
            win_right     = '0;
            rows_setting  = ROWS_RESET;
            cols_setting  = COLS_RESET;
            row_pos       = 0;
            col_pos       = 0;
            error_count   = 0;
            pending       = 0;
            checked_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_write)
            begin
                if (cfg_index == REG_GRID_ROWS)
                    rows_setting = cfg_data[ROW_W-1:0];
                else if (cfg_index == REG_GRID_COLS)
                    cols_setting = cfg_data[GRID_COLS_W-1:0];
            end
            if (in_valid && in_ready)
                predict_cell_average(sample);
            pending = expected_averages.size();
        end
    end

endmodule

/* tb/sv/four_neighbor_average_stencil_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_neighbor_average_stencil_unit_tb
// stream test of the four-neighbor average stencil unit
//
// feeds raster samples through a run of grid sizes: the reset size, a few
// hand-picked 3 x 3 frames with saturated and negative values, small random
// grids, degenerate sizes that give no averages, the largest row count, a
// clamped oversized column count and sizes shrunk under a frame in progress.
// sizes change only while the unit is idle. sender and receiver stall at
// random, and once the receiver holds off long enough to back up the input.
// the checker beside the unit predicts every average and scores the results.
// ----------------------------------------------------------------------------
module four_neighbor_average_stencil_unit_tb;
    import fnas_pkg::*;

    localparam int DW            = DEF_DATA_WIDTH;
    localparam int COL_W         = $clog2(DEF_MAX_COLS);
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 64;
    localparam int TOTAL_SAMPLES = 882;

    localparam logic signed [DW-1:0] SAMPLE_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAMPLE_MIN = {1'b1, {(DW-1){1'b0}}};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    cfg_reg_t              cfg_index = REG_GRID_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic signed [DW-1:0]  sample    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [DW-1:0]  average;
    logic [ROW_W-1:0]      cell_row;
    logic [COL_W-1:0]      cell_col;
    logic                  frame_done;

    int error_count;
    int pending_averages;
    int checked_averages;
    int send_idle_pct  = 15;
    int recv_idle_pct  = 80;
    int samples_sent   = 0;
    int sizes_used     = 1;
    int cycle_count    = 0;
    bit hold_req       = 1'b0;
    bit hold_done      = 1'b0;

    four_neighbor_average_stencil_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .average    (average),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .frame_done (frame_done)
    );

    four_neighbor_average_stencil_checker average_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .average       (average),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .frame_done    (frame_done),
        .error_count   (error_count),
        .pending       (pending_averages),
        .checked_count (checked_averages)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d averages owed",
                     cycle_count, pending_averages);
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic apply_sizes(input logic [CFG_DATA_W-1:0] rows,
                               input logic [CFG_DATA_W-1:0] cols);
        cfg_write <= 1'b1;
        cfg_index <= REG_GRID_ROWS;
        cfg_data  <= rows;
        @(negedge clk);
        cfg_index <= REG_GRID_COLS;
        cfg_data  <= cols;
        @(negedge clk);
        cfg_write <= 1'b0;
        sizes_used++;
    endtask

    task automatic wait_idle();
        while (pending_averages != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_phase(input int count, input bit directed, input int hold_at);
        logic signed [DW-1:0] value;
        int                   pick;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (samples_sent < TOTAL_SAMPLES / 3)
            begin
                send_idle_pct = 15;
                recv_idle_pct = 80;
            end
            else if (samples_sent < 2 * TOTAL_SAMPLES / 3)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 15;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (directed)
            begin
                // third frame: -2 below the center gives a sum of -5, which must truncate to -1, not -2
                case (i / 9)
                    0:       value = SAMPLE_MAX;
                    1:       value = SAMPLE_MIN;
                    default: value = (i % 9 == 7) ? -2 : -1;
                endcase
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    value = $urandom;
                else if (pick < 85)
                    value = $urandom_range(15) - 8;
                else
                begin
                    case ($urandom_range(3))
                        0:       value = SAMPLE_MAX;
                        1:       value = SAMPLE_MIN;
                        2:       value = '0;
                        default: value = -1;
                    endcase
                end
            end
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            sample   <= value;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            samples_sent++;
            @(negedge clk);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset size, left mid-frame and restarted by the next write
        send_phase(230, 1'b0, -1);
        wait_idle();
        apply_sizes(3, 3);
        send_phase(27, 1'b1, -1);
        wait_idle();
        apply_sizes(6, 7);
        send_phase(126, 1'b0, 20);
        wait_idle();
        apply_sizes(3, 3);
        send_phase(90, 1'b0, -1);
        wait_idle();
        // too few rows, then zero rows at full width, then zero columns
        apply_sizes(2, 5);
        send_phase(25, 1'b0, -1);
        wait_idle();
        apply_sizes(0, 1024);
        send_phase(30, 1'b0, -1);
        wait_idle();
        apply_sizes(4, 0);
        send_phase(12, 1'b0, -1);
        wait_idle();
        apply_sizes(65535, 3);
        send_phase(90, 1'b0, -1);
        wait_idle();
        apply_sizes(10, 12);
        send_phase(120, 1'b0, -1);
        wait_idle();
        // oversized column count clamps to the line store depth
        apply_sizes(3, 2047);
        send_phase(20, 1'b0, -1);
        wait_idle();
        apply_sizes(4, 5);
        send_phase(40, 1'b0, -1);
        wait_idle();
        apply_sizes(9, 8);
        send_phase(72, 1'b0, -1);
        wait_idle();

        $display("%0d samples streamed through %0d grid sizes, %0d averages checked",
                 samples_sent, sizes_used, checked_averages);
        $display("random stalls on both channels plus a %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
